### src/sha1md_pkg.sv
package sha1md_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned WinDepth  = 16;
  localparam int unsigned WinAddrW  = $clog2(WinDepth);
  localparam int unsigned RoundW    = 7;
  localparam int unsigned NumCv     = 5;
  localparam int unsigned CountW    = 64;

  localparam logic [RoundW-1:0] LastRound = 7'd79;
  localparam logic [2:0]        LastWord  = 3'd4;
  localparam logic [7:0]        PadByte   = 8'h80;

  typedef logic [NumCv-1:0][WordW-1:0] cv_t;

  // entry 0 sits in the low word
  localparam cv_t IvInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                            32'hEFCDAB89, 32'h67452301};

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLD,
    S_CMP,
    S_FIN,
    S_PADW,
    S_FILL,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
    logic iv;
  } round_ctl_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input int unsigned n);
    logic [2*WordW-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WordW-1:WordW];
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] r);
    logic [WordW-1:0] k;
    if (r < 7'd20) begin
      k = K0;
    end else if (r < 7'd40) begin
      k = K1;
    end else if (r < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RoundW-1:0] r,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

### src/sha1md_ram.sv
module sha1md_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### src/sha1md_round.sv
module sha1md_round
  import sha1md_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  round_ctl_t              ctl_i,
  input  logic [RoundW-1:0]       round_i,
  input  logic [WordW-1:0]        w_i,
  output cv_t                     cv_o
);

  cv_t              cv_q, cv_d;
  logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q;
  logic [WordW-1:0] t;

  assign t = rotl(a_q, 5) + round_f(round_i, b_q, c_q, d_q) + e_q + w_i
           + round_k(round_i);

  always_comb begin
    cv_d = cv_q;
    if (ctl_i.iv) begin
      cv_d = IvInit;
    end else if (ctl_i.fin) begin
      cv_d[0] = cv_q[0] + a_q;
      cv_d[1] = cv_q[1] + b_q;
      cv_d[2] = cv_q[2] + c_q;
      cv_d[3] = cv_q[3] + d_q;
      cv_d[4] = cv_q[4] + e_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= IvInit;
    end else begin
      cv_q <= cv_d;
    end
  end

  // working variables a..e
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= cv_q[0];
      b_q <= cv_q[1];
      c_q <= cv_q[2];
      d_q <= cv_q[3];
      e_q <= cv_q[4];
    end else if (ctl_i.step) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= rotl(b_q, 30);
      b_q <= a_q;
      a_q <= t;
    end
  end

  assign cv_o = cv_q;

endmodule

### src/sha1_message_digest_core.sv
// channel  | dir | handshake                | payload
// ---------+-----+--------------------------+------------------------------------------
// in       | in  | in_valid_i / in_ready_o  | data_byte_i, byte_valid_i, end_of_message_i
// out      | out | out_valid_o / out_ready_i| digest_word_o, word_position_o, final_word_o
//
// a byte item is taken whenever in_ready_o is high; every 64th byte starts a
// compression (load, 16 rounds on the block words, 64 rounds that each fetch and then expand and update, fold),
// paced by the two read ports of the schedule memory
// an end item adds one pad write plus fill steps for the block words after the
// pad word (at least one step), a fill of all sixteen words when the length spills into
// a further block, then one or two compressions, then five digest items, one
// per cycle unless out is stalled
// in_ready_o is low while a block compresses, pads or the digest is delivered
// rst_ni clears control and loads the initial chaining value; no clearing pass
module sha1_message_digest_core
  import sha1md_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 byte_valid_i,
  input  logic                 end_of_message_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WordW-1:0]     digest_word_o,
  output logic [2:0]           word_position_o,
  output logic                 final_word_o
);

  state_e              state_q, state_d;
  logic [RoundW-1:0]   round_q, round_d;
  logic                ph_q, ph_d;
  logic                last_q, last_d;
  logic                pad_q, pad_d;
  logic                extra_q, extra_d;
  logic [WinAddrW:0]   wp_q, wp_d;
  logic [2:0]          oi_q, oi_d;
  logic [CountW-1:0]   bits_q, bits_d;
  logic [WordW-1:0]    x_q, x_d;
  logic [23:0]         word_q, word_d;

  // schedule memory port signals
  logic                we;
  logic [WinAddrW-1:0] waddr, ra_a, ra_b;
  logic [WordW-1:0]    wdata, rd_a, rd_b;

  round_ctl_t          ctl;
  cv_t                 cv;

  logic [5:0]          off;
  logic [WordW-1:0]    pad_word;
  logic [WordW-1:0]    sched_w;
  logic [RoundW-1:0]   nxt;
  logic [WinAddrW-1:0] nlow;
  logic                early;

  // byte offset inside the current block
  assign off = bits_q[8:3];

  // partial word closed with the pad marker
  always_comb begin
    case (off[1:0])
      2'd0:    pad_word = {PadByte, 24'h0};
      2'd1:    pad_word = {word_q[7:0], PadByte, 16'h0};
      2'd2:    pad_word = {word_q[15:0], PadByte, 8'h0};
      2'd3:    pad_word = {word_q[23:0], PadByte};
      default: pad_word = '0;
    endcase
  end

  // first sixteen rounds read the block words directly, later ones expand
  assign early   = (round_q[6:4] == 3'd0);
  assign sched_w = early ? rd_a : rotl(x_q ^ rd_a ^ rd_b, 1);
  assign nxt     = round_q + 7'd1;
  assign nlow    = nxt[3:0];

  always_comb begin
    state_d    = state_q;
    round_d    = round_q;
    ph_d       = ph_q;
    last_d     = last_q;
    pad_d      = pad_q;
    extra_d    = extra_q;
    wp_d       = wp_q;
    oi_d       = oi_q;
    bits_d     = bits_q;
    x_d        = x_q;
    word_d     = word_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    ra_a       = '0;
    ra_b       = '0;
    ctl        = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          last_d = end_of_message_i;
          if (byte_valid_i) begin
            // pack big-endian, write once the word is complete
            word_d = {word_q[15:0], data_byte_i};
            bits_d = bits_q + 64'd8;
            if (off[1:0] == 2'd3) begin
              we    = 1'b1;
              waddr = off[5:2];
              wdata = {word_q, data_byte_i};
            end
            if (off == 6'd63) begin
              state_d = S_CLD;
            end else if (end_of_message_i) begin
              state_d = S_PADW;
            end
          end else if (end_of_message_i) begin
            state_d = S_PADW;
          end
        end
      end

      S_CLD: begin
        ctl.load = 1'b1;
        ra_a     = '0;
        round_d  = '0;
        ph_d     = 1'b0;
        state_d  = S_CMP;
      end

      S_CMP: begin
        if (early || ph_q) begin
          ctl.step = 1'b1;
          if (ph_q) begin
            // expanded word goes back in place
            we    = 1'b1;
            waddr = round_q[3:0];
            wdata = sched_w;
          end
          ph_d    = 1'b0;
          round_d = nxt;
          if (nxt[6:4] == 3'd0) begin
            ra_a = nlow;
          end else begin
            ra_a = nlow - 4'd3;
            ra_b = nlow - 4'd8;
          end
          if (round_q == LastRound) begin
            state_d = S_FIN;
          end
        end else begin
          // w[r-3] ^ w[r-8] held, now fetch w[r-14] and w[r-16]
          x_d  = rd_a ^ rd_b;
          ra_a = round_q[3:0] + 4'd2;
          ra_b = round_q[3:0];
          ph_d = 1'b1;
        end
      end

      S_FIN: begin
        ctl.fin = 1'b1;
        if (pad_q) begin
          if (extra_q) begin
            extra_d = 1'b0;
            wp_d    = '0;
            state_d = S_FILL;
          end else begin
            oi_d    = '0;
            state_d = S_OUT;
          end
        end else if (last_q) begin
          state_d = S_PADW;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_PADW: begin
        pad_d   = 1'b1;
        we      = 1'b1;
        waddr   = off[5:2];
        wdata   = pad_word;
        // a tail of 56 bytes or more pushes the length to a further block
        extra_d = (off[5:3] == 3'd7);
        wp_d    = {1'b0, off[5:2]} + 5'd1;
        state_d = S_FILL;
      end

      S_FILL: begin
        if (wp_q[WinAddrW]) begin
          state_d = S_CLD;
        end else begin
          we    = 1'b1;
          waddr = wp_q[3:0];
          if (!extra_q && wp_q[3:0] == 4'd14) begin
            wdata = bits_q[63:32];
          end else if (!extra_q && wp_q[3:0] == 4'd15) begin
            wdata = bits_q[31:0];
          end else begin
            wdata = '0;
          end
          if (wp_q[3:0] == 4'd15) begin
            state_d = S_CLD;
          end else begin
            wp_d = wp_q + 5'd1;
          end
        end
      end

      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (oi_q == LastWord) begin
            // back to the initial chaining value for the next message
            ctl.iv  = 1'b1;
            bits_d  = '0;
            pad_d   = 1'b0;
            last_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            oi_d = oi_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      round_q <= '0;
      ph_q    <= 1'b0;
      last_q  <= 1'b0;
      pad_q   <= 1'b0;
      extra_q <= 1'b0;
      wp_q    <= '0;
      oi_q    <= '0;
      bits_q  <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      ph_q    <= ph_d;
      last_q  <= last_d;
      pad_q   <= pad_d;
      extra_q <= extra_d;
      wp_q    <= wp_d;
      oi_q    <= oi_d;
      bits_q  <= bits_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    word_q <= word_d;
  end

  sha1md_ram #(
    .Width (WordW),
    .Depth (WinDepth)
  ) u_win (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (ra_a),
    .raddr_b_i (ra_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  sha1md_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .round_i (round_q),
    .w_i     (sched_w),
    .cv_o    (cv)
  );

  // digest words come straight from the chaining registers
  assign digest_word_o   = cv[oi_q];
  assign word_position_o = oi_q;
  assign final_word_o    = (oi_q == LastWord);

  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while digest pending");

  a_last_word_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && final_word_o) |=> !out_valid_o)
    else $error("digest continues after final word");

  a_digest_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (word_position_o == 3'd0))
    else $error("digest does not start at word zero");

  a_expand_late_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && ph_q) |-> (round_q[6:4] != 3'd0))
    else $error("expansion step in an early round");

endmodule
